// ----- src/gray_histogram_with_peak_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GRAY_HISTOGRAM_WITH_PEAK_DEFINES_SVH
`define GRAY_HISTOGRAM_WITH_PEAK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GHP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram check failed");

// Next-cycle implication, disabled during reset.
`define GHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram check failed");

`endif

// ----- src/ghp_pkg.sv -----
package ghp_pkg;

   localparam int BIN_COUNT           = 256;
   localparam int BIN_INDEX_WIDTH     = $clog2(BIN_COUNT);
   localparam int LEVEL_WIDTH         = 8;
   localparam int PIXEL_WIDTH         = 32;
   localparam int OP_WIDTH            = 2;
   localparam int OUT_COUNT_WIDTH     = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // operation codes; the spare code behaves as a read
   localparam logic [OP_WIDTH-1:0] OP_CLEAR      = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_READ       = 2'd2;

   // pixel format register values
   localparam logic FMT_GRAY8  = 1'b0;
   localparam logic FMT_ARGB32 = 1'b1;

   typedef struct packed {
      logic [OP_WIDTH-1:0]    operation;
      logic [PIXEL_WIDTH-1:0] pixel_word;
      logic [LEVEL_WIDTH-1:0] bin_index;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_COUNT_WIDTH-1:0] bin_count;
      logic [OUT_COUNT_WIDTH-1:0] peak_count;
      logic [LEVEL_WIDTH-1:0]     gray_level;
   } rsp_payload_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ghp_cmd_type;

endpackage

// ----- src/ghp_datapath.sv -----
module ghp_datapath #(
   parameter int COUNT_WIDTH = ghp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ghp_pkg::ghp_cmd_type     cmd,
   input  ghp_pkg::req_payload_type req_data,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   output ghp_pkg::rsp_payload_type rsp_data
);
   import ghp_pkg::*;

   localparam int ExtWidth = (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;
   localparam logic [OUT_COUNT_WIDTH-1:0] OutMax = '1;

   logic                       pixel_format_ff;
   logic [BIN_COUNT-1:0]       valid_ff;
   logic [COUNT_WIDTH-1:0]     bin_mem_ff [BIN_COUNT];
   logic [COUNT_WIDTH-1:0]     rd_data_ff;
   logic                       rd_valid_ff;
   logic [OP_WIDTH-1:0]        op_ff;
   logic [LEVEL_WIDTH-1:0]     level_ff;
   logic [COUNT_WIDTH-1:0]     peak_ff;
   logic [COUNT_WIDTH-1:0]     peak_in;
   rsp_payload_type            rsp_ff;

   logic [12:0]                luma_sum;
   logic [LEVEL_WIDTH-1:0]     pixel_level;
   logic [LEVEL_WIDTH-1:0]     level_in;
   logic [COUNT_WIDTH-1:0]     cur_count;
   logic [COUNT_WIDTH-1:0]     inc_count;
   logic [COUNT_WIDTH-1:0]     res_count;
   logic                       do_write;

   // clip a counter to the 32-bit result field
   function automatic logic [OUT_COUNT_WIDTH-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
      logic [ExtWidth-1:0] ext;
      ext = ExtWidth'(v);
      return (ext > ExtWidth'(OutMax)) ? OutMax : ext[OUT_COUNT_WIDTH-1:0];
   endfunction

   // weigh red, green and blue into one gray level
   always_comb begin
      luma_sum = {5'd0, req_data.pixel_word[23:16]} * 13'd11
               + {5'd0, req_data.pixel_word[15:8]}  * 13'd16
               + {5'd0, req_data.pixel_word[7:0]}   * 13'd5;
      pixel_level = (pixel_format_ff == FMT_ARGB32) ? luma_sum[12:5]
                                                    : req_data.pixel_word[7:0];
   end

   // pick the bin the item addresses
   always_comb begin
      case (req_data.operation)
         OP_CLEAR:      level_in = '0;
         OP_ACCUMULATE: level_in = pixel_level;
         default:       level_in = req_data.bin_index;
      endcase
   end

   // hold the pixel format register
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_GRAY8;
      end else if (csr_write_enable) begin
         pixel_format_ff <= csr_write_data;
      end
   end

   // capture the item and read its bin
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_data.operation;
         level_ff    <= level_in;
         rd_data_ff  <= bin_mem_ff[level_in[BIN_INDEX_WIDTH-1:0]];
         rd_valid_ff <= valid_ff[level_in[BIN_INDEX_WIDTH-1:0]];
      end
   end

   // work out the new count and peak
   always_comb begin
      cur_count = rd_valid_ff ? rd_data_ff : '0;
      inc_count = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);
      do_write  = 1'b0;
      peak_in   = peak_ff;
      case (op_ff)
         OP_CLEAR: begin
            res_count = '0;
            peak_in   = COUNT_WIDTH'(1);
         end
         OP_ACCUMULATE: begin
            res_count = inc_count;
            do_write  = 1'b1;
            if (inc_count > peak_ff) begin
               peak_in = inc_count;
            end
         end
         default: begin
            res_count = cur_count;
         end
      endcase
   end

   // write back the bin
   always_ff @(posedge clock) begin
      if (cmd.execute && do_write) begin
         bin_mem_ff[level_ff[BIN_INDEX_WIDTH-1:0]] <= inc_count;
      end
   end

   // track which bins hold a count since the last clear, and the peak
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         peak_ff  <= COUNT_WIDTH'(1);
      end else if (cmd.execute) begin
         peak_ff <= peak_in;
         if (op_ff == OP_CLEAR) begin
            valid_ff <= '0;
         end else if (do_write) begin
            valid_ff[level_ff[BIN_INDEX_WIDTH-1:0]] <= 1'b1;
         end
      end
   end

   // load the result register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff.bin_count  <= clip(res_count);
         rsp_ff.peak_count <= clip(peak_in);
         rsp_ff.gray_level <= level_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/ghp_controller.sv -----
module ghp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ghp_pkg::ghp_cmd_type cmd
);
   import ghp_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // take an item only when idle and the result register is free or emptying
   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_valid   = rsp_valid_ff;

   // advance state and hold the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (cmd.capture) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- src/gray_histogram_with_peak.sv -----
// Channel   Ports                                  Direction
// request   req_valid, req_ready, req_data         in
// response  rsp_valid, rsp_ready, rsp_data         out
// csr       csr_write_enable, csr_write_data       in
//
// Each item reads its bin from the count memory when it is captured; the execute
// state then writes the updated count back and loads the result register.
// A clear resets all bin valid flags at once; no sweep over the memory.
// Reset is synchronous and leaves every bin at zero and the peak at one.
// A waiting result holds the next item off until it is taken.
module gray_histogram_with_peak #(
   parameter int COUNT_WIDTH = ghp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ghp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ghp_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data
);
   import ghp_pkg::*;

   ghp_cmd_type cmd;

   // sequence each item
   ghp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // hold bins, peak and result
   ghp_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_data         (rsp_data)
   );

endmodule

// ----- src/ghp_checker.sv -----
`include "gray_histogram_with_peak_defines.svh"

module ghp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input ghp_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ghp_pkg::rsp_payload_type rsp_data
);
   import ghp_pkg::*;

   // a stalled result holds
   `GHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // one item in flight at a time
   `GHP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // the peak never drops below one
   `GHP_ASSERT_SAME(a_peak_nonzero, clock, reset, rsp_valid, rsp_data.peak_count != '0)

   // no bin exceeds the peak
   `GHP_ASSERT_SAME(a_bin_le_peak, clock, reset, rsp_valid, rsp_data.bin_count <= rsp_data.peak_count)

endmodule

bind gray_histogram_with_peak ghp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/tb_gray_histogram_with_peak.sv -----
`timescale 1ns / 1ps

module tb_gray_histogram_with_peak;
   import ghp_pkg::*;

   // spare operation code; the block treats it as a read
   localparam logic [OP_WIDTH-1:0] OP_SPARE = 2'd3;
   localparam logic [OUT_COUNT_WIDTH-1:0] COUNT_FULL = '1;
   localparam int DRAIN_LIMIT = 5000;
   localparam int PHASE_ITEMS = 170;
   localparam int REPORT_LIMIT = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data = 1'b0;

   // histogram state as the block should hold it
   logic [OUT_COUNT_WIDTH-1:0] bin_counts [BIN_COUNT];
   logic [OUT_COUNT_WIDTH-1:0] peak_so_far;
   logic                       format_now;

   rsp_payload_type expected_bin_reports [$];
   rsp_payload_type oldest_report;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int error_count = 0;
   logic [PIXEL_WIDTH-1:0] hot_colors [4];

   gray_histogram_with_peak u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // zero every bin and bring the peak back to one
   function automatic void clear_bin_counts();
      foreach (bin_counts[i]) bin_counts[i] = '0;
      peak_so_far = 1;
   endfunction

   // gray level of a pixel word under the given format
   function automatic logic [LEVEL_WIDTH-1:0] level_of_pixel(logic [PIXEL_WIDTH-1:0] word,
                                                            logic fmt);
      int unsigned weighted;
      weighted = 11 * int'(word[23:16]) + 16 * int'(word[15:8]) + 5 * int'(word[7:0]);
      if (fmt == FMT_ARGB32) begin
         return weighted[12:5];
      end
      return word[7:0];
   endfunction

   // apply one item to the histogram and return the report it produces
   function automatic rsp_payload_type predict_histogram_step(req_payload_type item);
      rsp_payload_type report;
      logic [LEVEL_WIDTH-1:0] level;
      logic [OUT_COUNT_WIDTH-1:0] count;
      report = '0;
      case (item.operation)
         OP_CLEAR: begin
            clear_bin_counts();
            report.bin_count = '0;
            report.gray_level = '0;
         end
         OP_ACCUMULATE: begin
            level = level_of_pixel(item.pixel_word, format_now);
            count = bin_counts[level];
            if (count != COUNT_FULL) begin
               count = count + 1;
            end
            bin_counts[level] = count;
            if (count > peak_so_far) begin
               peak_so_far = count;
            end
            report.bin_count = count;
            report.gray_level = level;
         end
         default: begin
            report.bin_count = bin_counts[item.bin_index];
            report.gray_level = item.bin_index;
         end
      endcase
      report.peak_count = peak_so_far;
      return report;
   endfunction

   // offer one item, hold it until taken, then record its expected report
   task automatic offer_pixel_op(logic [OP_WIDTH-1:0] op, logic [PIXEL_WIDTH-1:0] pixel,
                                 logic [LEVEL_WIDTH-1:0] index);
      req_payload_type item;
      item.operation = op;
      item.pixel_word = pixel;
      item.bin_index = index;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_bin_reports.push_back(predict_histogram_step(item));
   endtask

   // drop valid and wait for every outstanding report
   task automatic drain_reports();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bin_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_bin_reports.size() != 0) begin
         error_count += expected_bin_reports.size();
         $display("%0d reports never arrived", expected_bin_reports.size());
         expected_bin_reports.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // write the pixel format register while the block is idle
   task automatic write_pixel_format(logic fmt);
      drain_reports();
      csr_write_data <= fmt;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      format_now = fmt;
   endtask

   // take reports, compare with the oldest expectation, drive ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bin_reports.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("unexpected report: count %0d peak %0d level %0d",
                           rsp_data.bin_count, rsp_data.peak_count, rsp_data.gray_level);
               end
            end else begin
               oldest_report = expected_bin_reports.pop_front();
               if (rsp_data.bin_count !== oldest_report.bin_count
                   || rsp_data.peak_count !== oldest_report.peak_count
                   || rsp_data.gray_level !== oldest_report.gray_level) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("mismatch: expected count %0d peak %0d level %0d, got %0d %0d %0d",
                              oldest_report.bin_count, oldest_report.peak_count,
                              oldest_report.gray_level, rsp_data.bin_count,
                              rsp_data.peak_count, rsp_data.gray_level);
                  end
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // gray format: empty reads, byte extremes, repeated hits, spare code, clear
   task automatic test_gray_directed();
      write_pixel_format(FMT_GRAY8);
      offer_pixel_op(OP_READ, $urandom(), 8'h00);
      offer_pixel_op(OP_READ, $urandom(), 8'hFF);
      offer_pixel_op(OP_ACCUMULATE, 32'h0000_0000, 8'h00);
      offer_pixel_op(OP_ACCUMULATE, 32'hFFFF_FFFF, 8'hFF);
      repeat (3) offer_pixel_op(OP_ACCUMULATE, 32'hABCD_EF07, 8'h00);
      offer_pixel_op(OP_READ, 32'hFFFF_FFFF, 8'h07);
      offer_pixel_op(OP_SPARE, 32'h0000_0000, 8'h07);
      offer_pixel_op(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF);
      offer_pixel_op(OP_READ, 32'h0000_0000, 8'h07);
      offer_pixel_op(OP_ACCUMULATE, 32'h5432_1080, 8'h00);
      offer_pixel_op(OP_READ, 32'h0000_0000, 8'h80);
   endtask

   // ARGB format: each channel alone, all ones, alpha ignored
   task automatic test_argb_directed();
      write_pixel_format(FMT_ARGB32);
      offer_pixel_op(OP_ACCUMULATE, 32'hFFFF_FFFF, 8'h00);
      offer_pixel_op(OP_ACCUMULATE, 32'h0000_0000, 8'h00);
      offer_pixel_op(OP_ACCUMULATE, 32'h00FF_0000, 8'h00);
      offer_pixel_op(OP_ACCUMULATE, 32'h0000_FF00, 8'h00);
      offer_pixel_op(OP_ACCUMULATE, 32'h0000_00FF, 8'h00);
      offer_pixel_op(OP_ACCUMULATE, 32'hFF00_0000, 8'h00);
      offer_pixel_op(OP_SPARE, 32'h0000_0000, 8'd87);
      offer_pixel_op(OP_READ, 32'h0000_0000, 8'd0);
      offer_pixel_op(OP_READ, 32'h0000_0000, 8'd255);
   endtask

   // random mix of operations, hot colors to build tall bins and back-to-back hits
   task automatic test_random_phases();
      int idle_table [4];
      int stall_table [4];
      int pick;
      logic [OP_WIDTH-1:0] op;
      logic [PIXEL_WIDTH-1:0] pixel;
      logic [LEVEL_WIDTH-1:0] index;
      idle_table = '{0, 48, 0, 12};
      stall_table = '{0, 0, 48, 12};
      for (int phase = 0; phase < 4; phase++) begin
         write_pixel_format(phase % 2 ? FMT_ARGB32 : FMT_GRAY8);
         send_idle_pct = idle_table[phase];
         recv_stall_pct = stall_table[phase];
         foreach (hot_colors[i]) hot_colors[i] = $urandom();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               op = OP_CLEAR;
            end else if (pick < 7) begin
               op = OP_SPARE;
            end else if (pick < 35) begin
               op = OP_READ;
            end else begin
               op = OP_ACCUMULATE;
            end
            pixel = $urandom();
            if ($urandom_range(0, 1)) begin
               pixel[23:0] = hot_colors[2'($urandom_range(0, 3))][23:0];
            end
            if ($urandom_range(0, 1)) begin
               index = level_of_pixel(hot_colors[2'($urandom_range(0, 3))], format_now);
            end else begin
               index = 8'($urandom_range(0, 255));
            end
            offer_pixel_op(op, pixel, index);
         end
      end
   endtask

   // hold the receiver off for a long stretch while items keep coming
   task automatic test_backpressure();
      write_pixel_format(FMT_ARGB32);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 150;
      for (int n = 0; n < 40; n++) begin
         offer_pixel_op(n % 5 == 4 ? OP_READ : OP_ACCUMULATE,
                        {8'($urandom_range(0, 255)), hot_colors[n % 2][23:0]},
                        level_of_pixel(hot_colors[0], FMT_ARGB32));
      end
      write_pixel_format(FMT_GRAY8);
   endtask

   initial begin
      clear_bin_counts();
      format_now = FMT_GRAY8;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_gray_directed();
      test_argb_directed();
      test_random_phases();
      test_backpressure();
      drain_reports();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
